FILE: sv/gmd_pkg.sv
// ----------------------------------------------------------------------------
// gmd_pkg
// Shared types and constants for the grid maze depth-first path search.
// ----------------------------------------------------------------------------
package gmd_pkg;

    // Fixed field widths of the request and result channels.
    localparam int IDX_W  = 4;
    localparam int MASK_W = 12;

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_SOLVE = 1'b1
    } action_t;

    // Search direction of a stack entry; DIR_DONE means all four were tried.
    typedef enum logic [2:0]
    {
        DIR_N    = 3'd0,
        DIR_E    = 3'd1,
        DIR_S    = 3'd2,
        DIR_W    = 3'd3,
        DIR_DONE = 3'd4
    } dir_t;

    // Status of the neighbor under test.
    typedef struct packed
    {
        logic ok;   // neighbor lies inside the grid
        logic hit;  // neighbor is the goal cell
    } nbr_t;

endpackage

FILE: sv/gmd_in_if.sv
// ----------------------------------------------------------------------------
// gmd_in_if
// Request channel: a row load or a solve request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gmd_in_if;

    logic                            valid;
    logic                            ready;
    gmd_pkg::action_t                action;
    logic [gmd_pkg::IDX_W-1:0]       row_index;
    logic [gmd_pkg::MASK_W-1:0]      wall_mask;
    logic [gmd_pkg::IDX_W-1:0]       start_row;
    logic [gmd_pkg::IDX_W-1:0]       start_col;
    logic [gmd_pkg::IDX_W-1:0]       end_row;
    logic [gmd_pkg::IDX_W-1:0]       end_col;

    modport source
    (
        output valid, action, row_index, wall_mask, start_row, start_col, end_row, end_col,
        input  ready
    );

    modport sink
    (
        input  valid, action, row_index, wall_mask, start_row, start_col, end_row, end_col,
        output ready
    );

endinterface

FILE: sv/gmd_out_if.sv
// ----------------------------------------------------------------------------
// gmd_out_if
// Result channel: one path row per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gmd_out_if;

    logic                            valid;
    logic                            ready;
    logic                            found;
    logic [gmd_pkg::IDX_W-1:0]       out_row;
    logic [gmd_pkg::MASK_W-1:0]      path_mask;
    logic                            last;

    modport source
    (
        output valid, found, out_row, path_mask, last,
        input  ready
    );

    modport sink
    (
        input  valid, found, out_row, path_mask, last,
        output ready
    );

endinterface

FILE: sv/gmd_nbr.sv
// ----------------------------------------------------------------------------
// gmd_nbr
// Neighbor unit: steps from the current cell in one direction, checks the
// grid bounds and compares the result against the goal cell.
// ----------------------------------------------------------------------------
module gmd_nbr #(
    parameter int GRID_ROWS = 12,
    parameter int GRID_COLS = 12
) (
    input  logic [$clog2(GRID_ROWS)-1:0] cur_row,
    input  logic [$clog2(GRID_COLS)-1:0] cur_col,
    input  gmd_pkg::dir_t                dir,
    input  logic [gmd_pkg::IDX_W-1:0]    end_row,
    input  logic [gmd_pkg::IDX_W-1:0]    end_col,
    output logic [$clog2(GRID_ROWS)-1:0] nbr_row,
    output logic [$clog2(GRID_COLS)-1:0] nbr_col,
    output gmd_pkg::nbr_t                info
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);

    logic ok;

    always_comb
    begin
        nbr_row = cur_row;
        nbr_col = cur_col;
        ok      = 1'b0;
        unique case (dir)
            gmd_pkg::DIR_N:
            begin
                ok      = (cur_row != '0);
                nbr_row = cur_row - RW'(1);
            end
            gmd_pkg::DIR_E:
            begin
                ok      = (cur_col != CW'(GRID_COLS - 1));
                nbr_col = cur_col + CW'(1);
            end
            gmd_pkg::DIR_S:
            begin
                ok      = (cur_row != RW'(GRID_ROWS - 1));
                nbr_row = cur_row + RW'(1);
            end
            gmd_pkg::DIR_W:
            begin
                ok      = (cur_col != '0);
                nbr_col = cur_col - CW'(1);
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign info.ok  = ok;
    assign info.hit = ok && (gmd_pkg::IDX_W'(nbr_row) == end_row)
                         && (gmd_pkg::IDX_W'(nbr_col) == end_col);

endmodule

FILE: sv/grid_maze_dfs_path_search.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_search
// Depth-first maze solver over a grid of wall bits, one search step a cycle.
// ----------------------------------------------------------------------------
// Usage:
// The request channel cmd takes two kinds of request. A load request writes
// one grid row of wall bits and is absorbed with no result. A
// solve request searches from the start cell to the goal cell, trying north,
// east, south and west in that order, and then sends GRID_ROWS results on
// res, one per row, each with the found flag and the mask of path cells.
// The goal counts as reached even if it is a wall; the start is on the path
// and the goal is not.
// Sequence: a solve runs the start checks, then tries the directions in
// turn; a backtrack passes through S_STEP and S_RELOAD (the stack memory
// has a registered read port and a separate write port). The GRID_ROWS
// result transfers follow. The search has a single neighbor unit. cmd is
// not ready from a solve request until its last result has been taken.
// A stall on res simply holds the current result; no state advances.
// Reset clears the walls, the visited marks and res.valid; cmd leaves reset ready.
// ----------------------------------------------------------------------------
module grid_maze_dfs_path_search #(
    parameter int GRID_ROWS = 12,
    parameter int GRID_COLS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    gmd_in_if.sink    cmd,
    gmd_out_if.source res
);

    localparam int RW     = $clog2(GRID_ROWS);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int MW     = gmd_pkg::MASK_W;
    localparam int ROW_W  = (GRID_COLS > MW) ? GRID_COLS : MW;
    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int AW     = $clog2(CELLS);
    localparam int SPW    = $clog2(CELLS + 1);
    localparam int ENT_W  = RW + CW + 3;
    localparam logic [ROW_W-1:0] COL_MASK = ROW_W'((64'd1 << GRID_COLS) - 64'd1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_INIT,
        S_STEP,
        S_RELOAD,
        S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [SPW-1:0]          sp_reg, sp_next;
    logic [RW-1:0]           cur_r_reg, cur_r_next;
    logic [CW-1:0]           cur_c_reg, cur_c_next;
    gmd_pkg::dir_t           cur_d_reg, cur_d_next;
    logic [3:0]              sr_reg, sr_next;
    logic [3:0]              sc_reg, sc_next;
    logic [3:0]              er_reg, er_next;
    logic [3:0]              ec_reg, ec_next;
    logic                    found_reg, found_next;
    logic [ROW_W-1:0]        wall_reg [GRID_ROWS];
    logic [ROW_W-1:0]        wall_next [GRID_ROWS];
    logic [ROW_W-1:0]        vis_reg [GRID_ROWS];
    logic [ROW_W-1:0]        vis_next [GRID_ROWS];
    logic [ROW_W-1:0]        path_reg [GRID_ROWS];
    logic [ROW_W-1:0]        path_next [GRID_ROWS];
    logic                    out_valid_reg, out_valid_next;
    logic [RW-1:0]           out_row_reg, out_row_next;
    logic [MW-1:0]           out_mask_reg, out_mask_next;
    logic                    out_last_reg, out_last_next;

    // Search stack below the top entry; the top entry lives in cur_*_reg.
    logic [ENT_W-1:0]        stk_mem [CELLS];
    logic [ENT_W-1:0]        stk_rdata_reg;
    logic                    stk_we;
    logic [AW-1:0]           stk_waddr;
    logic [AW-1:0]           stk_raddr;
    logic [ENT_W-1:0]        stk_wdata;

    logic [RW-1:0]           nbr_row;
    logic [CW-1:0]           nbr_col;
    gmd_pkg::nbr_t           nbr;
    gmd_pkg::dir_t           dir_inc;
    logic [SPW-1:0]          sp_m1;
    logic [SPW-1:0]          sp_m2;
    logic [RW-1:0]           row_inc;
    logic [RW-1:0]           rd_row;
    logic [CW-1:0]           rd_col;
    logic                    wall_bit;
    logic                    vis_bit;
    logic                    start_in;

    gmd_nbr #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_nbr (
        .cur_row (cur_r_reg),
        .cur_col (cur_c_reg),
        .dir     (cur_d_reg),
        .end_row (er_reg),
        .end_col (ec_reg),
        .nbr_row (nbr_row),
        .nbr_col (nbr_col),
        .info    (nbr)
    );

    assign dir_inc  = gmd_pkg::dir_t'(3'(cur_d_reg) + 3'd1);
    assign sp_m1    = sp_reg - SPW'(1);
    assign sp_m2    = sp_reg - SPW'(2);
    assign row_inc  = out_row_reg + RW'(1);
    assign start_in = (5'(sr_reg) < 5'(GRID_ROWS)) && (5'(sc_reg) < 5'(GRID_COLS));

    // The wall grid has a single read port: the start cell during the start
    // checks, the neighbor under test otherwise.
    assign rd_row   = (state_reg == S_INIT) ? sr_reg[RW-1:0] : nbr_row;
    assign rd_col   = (state_reg == S_INIT) ? sc_reg[CW-1:0] : nbr_col;
    assign wall_bit = wall_reg[rd_row][rd_col];
    assign vis_bit  = vis_reg[nbr_row][nbr_col];

    assign stk_waddr = sp_m1[AW-1:0];
    assign stk_raddr = sp_m2[AW-1:0];
    assign stk_wdata = {cur_r_reg, cur_c_reg, 3'(dir_inc)};

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        cur_d_next     = cur_d_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        er_next        = er_reg;
        ec_next        = ec_reg;
        found_next     = found_reg;
        wall_next      = wall_reg;
        vis_next       = vis_reg;
        path_next      = path_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_mask_next  = out_mask_reg;
        out_last_next  = out_last_reg;
        stk_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.action == gmd_pkg::ACT_SOLVE)
                    begin
                        sr_next    = cmd.start_row;
                        sc_next    = cmd.start_col;
                        er_next    = cmd.end_row;
                        ec_next    = cmd.end_col;
                        sp_next    = '0;
                        found_next = 1'b0;
                        vis_next   = '{default: '0};
                        path_next  = '{default: '0};
                        state_next = S_INIT;
                    end
                    else if (5'(cmd.row_index) < 5'(GRID_ROWS))
                    begin
                        wall_next[cmd.row_index[RW-1:0]] = ROW_W'(cmd.wall_mask) & COL_MASK;
                    end
                end
            end

            S_INIT:
            begin
                out_row_next  = '0;
                out_mask_next = '0;
                out_last_next = 1'b0;
                priority if (!start_in)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else if (sr_reg == er_reg && sc_reg == ec_reg)
                begin
                    // Start equals goal: found, with an empty path.
                    found_next     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else if (wall_bit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    cur_r_next = sr_reg[RW-1:0];
                    cur_c_next = sc_reg[CW-1:0];
                    cur_d_next = gmd_pkg::DIR_N;
                    sp_next    = SPW'(1);
                    vis_next[sr_reg[RW-1:0]][sc_reg[CW-1:0]]  = 1'b1;
                    path_next[sr_reg[RW-1:0]][sc_reg[CW-1:0]] = 1'b1;
                    state_next = S_STEP;
                end
            end

            S_STEP:
            begin
                if (cur_d_reg == gmd_pkg::DIR_DONE)
                begin
                    // Backtrack: drop the top cell from the path.
                    sp_next = sp_m1;
                    path_next[cur_r_reg][cur_c_reg] = 1'b0;
                    if (sp_reg == SPW'(1))
                    begin
                        out_row_next   = '0;
                        out_mask_next  = '0;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RELOAD;
                    end
                end
                else
                begin
                    cur_d_next = dir_inc;
                    if (nbr.ok)
                    begin
                        priority if (nbr.hit)
                        begin
                            found_next     = 1'b1;
                            out_row_next   = '0;
                            out_mask_next  = path_reg[0][MW-1:0];
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                        else if (!wall_bit && !vis_bit)
                        begin
                            stk_we     = 1'b1;
                            cur_r_next = nbr_row;
                            cur_c_next = nbr_col;
                            cur_d_next = gmd_pkg::DIR_N;
                            sp_next    = sp_reg + SPW'(1);
                            vis_next[nbr_row][nbr_col]  = 1'b1;
                            path_next[nbr_row][nbr_col] = 1'b1;
                        end
                        else
                        begin
                            cur_d_next = dir_inc;
                        end
                    end
                end
            end

            S_RELOAD:
            begin
                cur_r_next = stk_rdata_reg[ENT_W-1:CW+3];
                cur_c_next = stk_rdata_reg[CW+2:3];
                cur_d_next = gmd_pkg::dir_t'(stk_rdata_reg[2:0]);
                state_next = S_STEP;
            end

            S_OUT:
            begin
                if (res.ready)
                begin
                    if (out_last_reg)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_row_next  = row_inc;
                        out_mask_next = found_reg ? path_reg[row_inc][MW-1:0] : '0;
                        out_last_next = (row_inc == RW'(GRID_ROWS - 1));
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            found_reg     <= 1'b0;
            wall_reg      <= '{default: '0};
            vis_reg       <= '{default: '0};
            path_reg      <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            found_reg     <= found_next;
            wall_reg      <= wall_next;
            vis_reg       <= vis_next;
            path_reg      <= path_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_r_reg    <= cur_r_next;
        cur_c_reg    <= cur_c_next;
        cur_d_reg    <= cur_d_next;
        sr_reg       <= sr_next;
        sc_reg       <= sc_next;
        er_reg       <= er_next;
        ec_reg       <= ec_next;
        out_row_reg  <= out_row_next;
        out_mask_reg <= out_mask_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    assign cmd.ready     = (state_reg == S_IDLE);
    assign res.valid     = out_valid_reg;
    assign res.found     = found_reg;
    assign res.out_row   = gmd_pkg::IDX_W'(out_row_reg);
    assign res.path_mask = out_mask_reg;
    assign res.last      = out_last_reg;

`ifndef SYNTHESIS
    // A new request is never taken while results are still pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && res.valid))
        else $error("request channel ready while results pending");

    // The stack never holds more entries than the grid has cells.
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(CELLS))
        else $error("stack pointer beyond grid size");

    // A search step always has a top cell to work from.
    a_step_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (sp_reg != '0))
        else $error("search step with empty stack");

    // Taking the last result of a solve frees the request channel.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last) |=> cmd.ready)
        else $error("request channel not ready after last result");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid maze depth-first path search. A queue of
// row loads and solve requests feeds a clocked driver. A clocked monitor
// compares every path row against a local depth-first predictor, while both
// channels idle at random and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS         = 12;
    localparam int COLS         = 12;
    localparam int CELL_CNT     = ROWS * COLS;
    localparam int RANDOM_ITEMS = 175;
    localparam int LIMIT_CYCLES = 750000;
    localparam int QUIET_LO     = 10000;
    localparam int QUIET_HI     = 25000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_FIRST   = 1500;
    localparam int HOLD_SECOND  = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        gmd_pkg::action_t                action;
        logic [gmd_pkg::IDX_W-1:0]       row_index;
        logic [gmd_pkg::MASK_W-1:0]      wall_mask;
        logic [gmd_pkg::IDX_W-1:0]       start_row;
        logic [gmd_pkg::IDX_W-1:0]       start_col;
        logic [gmd_pkg::IDX_W-1:0]       end_row;
        logic [gmd_pkg::IDX_W-1:0]       end_col;
    } maze_req_t;

    typedef struct {
        logic                            found;
        logic [gmd_pkg::IDX_W-1:0]       out_row;
        logic [gmd_pkg::MASK_W-1:0]      path_mask;
        logic                            last;
    } path_row_t;

    logic clk = 1'b0;
    logic rst_n;

    gmd_in_if  cmd_bus ();
    gmd_out_if res_bus ();

    grid_maze_dfs_path_search #(
        .GRID_ROWS (ROWS),
        .GRID_COLS (COLS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    always #4 clk = ~clk;

    maze_req_t                   req_queue [$];
    path_row_t                   rows_due [$];
    logic [gmd_pkg::MASK_W-1:0]  wall_map [ROWS];

    int cycle       = 0;
    int err_cnt     = 0;
    int load_cnt    = 0;
    int solve_cnt   = 0;
    int found_cnt   = 0;
    int rows_seen   = 0;
    int hold_left   = 0;
    int holds_done  = 0;
    int useful_cnt  = 0;

    // Both channels run without gaps inside the quiet window.
    function automatic bit idle_draw();
        if (cycle >= QUIET_LO && cycle < QUIET_HI)
            return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    function automatic logic [gmd_pkg::MASK_W-1:0] random_walls(int pct);
        logic [gmd_pkg::MASK_W-1:0] m;
        m = '0;
        for (int c = 0; c < gmd_pkg::MASK_W; c++)
            m[c] = ($urandom_range(99) < pct);
        return m;
    endfunction

    // The solve fields of a load request carry noise; the block ignores them.
    task automatic queue_load(int idx, logic [gmd_pkg::MASK_W-1:0] walls);
        maze_req_t q;
        q.action    = gmd_pkg::ACT_LOAD;
        q.row_index = gmd_pkg::IDX_W'(idx);
        q.wall_mask = walls;
        q.start_row = gmd_pkg::IDX_W'($urandom);
        q.start_col = gmd_pkg::IDX_W'($urandom);
        q.end_row   = gmd_pkg::IDX_W'($urandom);
        q.end_col   = gmd_pkg::IDX_W'($urandom);
        req_queue.push_back(q);
    endtask

    task automatic queue_solve(int sr, int sc, int er, int ec);
        maze_req_t q;
        q.action    = gmd_pkg::ACT_SOLVE;
        q.row_index = gmd_pkg::IDX_W'($urandom);
        q.wall_mask = gmd_pkg::MASK_W'($urandom);
        q.start_row = gmd_pkg::IDX_W'(sr);
        q.start_col = gmd_pkg::IDX_W'(sc);
        q.end_row   = gmd_pkg::IDX_W'(er);
        q.end_col   = gmd_pkg::IDX_W'(ec);
        req_queue.push_back(q);
    endtask

    // Applies one accepted request to the local maze copy and queues the
    // path rows a solve must produce.
    task automatic predict_maze_request(maze_req_t q);
        logic [gmd_pkg::MASK_W-1:0] seen [ROWS];
        logic [gmd_pkg::MASK_W-1:0] path [ROWS];
        int                         stk_r [CELL_CNT];
        int                         stk_c [CELL_CNT];
        gmd_pkg::dir_t              stk_d [CELL_CNT];
        gmd_pkg::dir_t              d;
        int                         sr, sc, er, ec, nr, nc, sp, top;
        bit                         hit;
        path_row_t                  pr;
        if (q.action == gmd_pkg::ACT_LOAD)
        begin
            load_cnt++;
            if (int'(q.row_index) < ROWS)
                wall_map[q.row_index] = q.wall_mask;
        end
        else
        begin
            solve_cnt++;
            sr = int'(q.start_row);
            sc = int'(q.start_col);
            er = int'(q.end_row);
            ec = int'(q.end_col);
            for (int i = 0; i < ROWS; i++)
            begin
                seen[i] = '0;
                path[i] = '0;
            end
            sp  = 0;
            hit = 1'b0;
            if (sr >= ROWS || sc >= COLS)
                hit = 1'b0;
            else if (sr == er && sc == ec)
                hit = 1'b1;
            else if (!wall_map[sr][sc])
            begin
                stk_r[0]     = sr;
                stk_c[0]     = sc;
                stk_d[0]     = gmd_pkg::DIR_N;
                seen[sr][sc] = 1'b1;
                sp           = 1;
                while (sp > 0 && !hit)
                begin
                    top = sp - 1;
                    d   = stk_d[top];
                    if (d == gmd_pkg::DIR_DONE)
                        sp--;
                    else
                    begin
                        stk_d[top] = gmd_pkg::dir_t'(int'(d) + 1);
                        nr = stk_r[top];
                        nc = stk_c[top];
                        case (d)
                            gmd_pkg::DIR_N: nr--;
                            gmd_pkg::DIR_E: nc++;
                            gmd_pkg::DIR_S: nr++;
                            default:        nc--;
                        endcase
                        if (nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS)
                        begin
                            // The goal is reached even when it is a wall.
                            if (nr == er && nc == ec)
                                hit = 1'b1;
                            else if (!wall_map[nr][nc] && !seen[nr][nc])
                            begin
                                stk_r[sp]    = nr;
                                stk_c[sp]    = nc;
                                stk_d[sp]    = gmd_pkg::DIR_N;
                                seen[nr][nc] = 1'b1;
                                sp++;
                            end
                        end
                    end
                end
            end
            if (hit)
            begin
                found_cnt++;
                for (int i = 0; i < sp; i++)
                    path[stk_r[i]][stk_c[i]] = 1'b1;
            end
            for (int r = 0; r < ROWS; r++)
            begin
                pr.found     = hit;
                pr.out_row   = gmd_pkg::IDX_W'(r);
                pr.path_mask = path[r];
                pr.last      = (r == ROWS - 1);
                rows_due.push_back(pr);
            end
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        maze_req_t acc;
        maze_req_t nxt;
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                acc.action    = cmd_bus.action;
                acc.row_index = cmd_bus.row_index;
                acc.wall_mask = cmd_bus.wall_mask;
                acc.start_row = cmd_bus.start_row;
                acc.start_col = cmd_bus.start_col;
                acc.end_row   = cmd_bus.end_row;
                acc.end_col   = cmd_bus.end_col;
                predict_maze_request(acc);
            end
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (req_queue.size() > 0 && !idle_draw())
                begin
                    nxt = req_queue.pop_front();
                    cmd_bus.valid     <= 1'b1;
                    cmd_bus.action    <= nxt.action;
                    cmd_bus.row_index <= nxt.row_index;
                    cmd_bus.wall_mask <= nxt.wall_mask;
                    cmd_bus.start_row <= nxt.start_row;
                    cmd_bus.start_col <= nxt.start_col;
                    cmd_bus.end_row   <= nxt.end_row;
                    cmd_bus.end_col   <= nxt.end_col;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off counter: two long stretches, each started while a
    // path row is waiting, so the solver backs up into the request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (res_bus.valid &&
                 ((holds_done == 0 && cycle >= HOLD_FIRST) ||
                  (holds_done == 1 && cycle >= HOLD_SECOND)))
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Result monitor and receiver ready.
    always @(posedge clk or negedge rst_n)
    begin
        path_row_t want;
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                rows_seen++;
                if (rows_due.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected path row, expected none, actual row %0d mask %0h",
                             $time, res_bus.out_row, res_bus.path_mask);
                end
                else
                begin
                    want = rows_due.pop_front();
                    check_field("found", 32'(want.found), 32'(res_bus.found));
                    check_field("out_row", 32'(want.out_row), 32'(res_bus.out_row));
                    check_field("path_mask", 32'(want.path_mask), 32'(res_bus.path_mask));
                    check_field("last", 32'(want.last), 32'(res_bus.last));
                end
            end
            res_bus.ready <= (hold_left == 0) && !idle_draw();
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= LIMIT_CYCLES)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int n_rows, n_solves, idx, pct, sr, sc, er, ec;
        rst_n             = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.action    = gmd_pkg::ACT_LOAD;
        cmd_bus.row_index = '0;
        cmd_bus.wall_mask = '0;
        cmd_bus.start_row = '0;
        cmd_bus.start_col = '0;
        cmd_bus.end_row   = '0;
        cmd_bus.end_col   = '0;
        res_bus.ready     = 1'b0;
        for (int r = 0; r < ROWS; r++)
            wall_map[r] = '0;

        // Directed part: open grid, start on goal, walls, out-of-grid cells.
        queue_solve(0, 0, 11, 11);
        queue_solve(5, 5, 5, 5);
        queue_load(0, 12'hFFF);
        queue_load(15, 12'hFFF);
        queue_load(12, 12'h0F0);
        queue_solve(0, 3, 5, 5);
        queue_solve(0, 3, 0, 3);
        queue_solve(12, 0, 1, 1);
        queue_solve(0, 15, 1, 1);
        queue_solve(13, 13, 13, 13);
        queue_solve(1, 0, 14, 2);
        queue_solve(1, 0, 0, 0);
        queue_load(1, 12'h002);
        queue_load(2, 12'h003);
        queue_solve(1, 0, 11, 11);
        queue_load(0, 12'h000);
        queue_load(1, 12'h000);
        queue_load(2, 12'h000);
        queue_load(11, 12'hAAA);
        queue_load(10, 12'h555);
        queue_solve(0, 11, 11, 0);
        queue_solve(11, 0, 0, 11);
        queue_load(10, 12'h000);
        queue_load(11, 12'h000);

        // Random part: a few row loads, then one or two solves on that maze.
        while (useful_cnt < RANDOM_ITEMS)
        begin
            n_rows = $urandom_range(1, 6);
            pct    = $urandom_range(10, 40);
            for (int i = 0; i < n_rows; i++)
            begin
                if ($urandom_range(9) == 0)
                    queue_load($urandom_range(12, 15), gmd_pkg::MASK_W'($urandom));
                else
                begin
                    idx = $urandom_range(0, ROWS - 1);
                    case ($urandom_range(19))
                        0:       queue_load(idx, 12'hFFF);
                        1:       queue_load(idx, 12'h000);
                        default: queue_load(idx, random_walls(pct));
                    endcase
                    useful_cnt++;
                end
            end
            n_solves = $urandom_range(1, 2);
            for (int i = 0; i < n_solves; i++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    sr = $urandom_range(0, 15);
                    sc = $urandom_range(0, 15);
                    er = $urandom_range(0, 15);
                    ec = $urandom_range(0, 15);
                end
                else
                begin
                    sr = $urandom_range(0, ROWS - 1);
                    sc = $urandom_range(0, COLS - 1);
                    er = $urandom_range(0, ROWS - 1);
                    ec = $urandom_range(0, COLS - 1);
                    if ($urandom_range(19) == 0)
                    begin
                        er = sr;
                        ec = sc;
                    end
                end
                queue_solve(sr, sc, er, ec);
                useful_cnt++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (req_queue.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d row loads and %0d solves sent, %0d solves reached the goal",
                 load_cnt, solve_cnt, found_cnt);
        $display("tb: %0d path rows checked over %0d cycles", rows_seen, cycle);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
